// ===== rtl/icmr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icmr_pkg
// Shared types and constants of the interrupt cause/mask register block.
// ----------------------------------------------------------------------------
package icmr_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned OFFSET_W = 12;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned PTR_LSB  = 5;
   localparam int unsigned PTR_W    = DATA_W - PTR_LSB;

   // Cause bit driven by the (active low) reset button.
   localparam int unsigned RESET_BUTTON_BIT = 16;
   localparam logic [DATA_W-1:0] BUTTON_MASK = DATA_W'(1) << RESET_BUTTON_BIT;
   localparam logic [DATA_W-1:0] CAUSE_RESET = BUTTON_MASK;

   typedef enum logic [KIND_W-1:0] {
      KIND_READ   = 2'd0,
      KIND_WRITE  = 2'd1,
      KIND_LINE   = 2'd2,
      KIND_BUTTON = 2'd3
   } kind_type;

   // Register offsets, low 12 address bits.
   localparam logic [OFFSET_W-1:0] OFS_CAUSE     = 12'h000;
   localparam logic [OFFSET_W-1:0] OFS_MASK      = 12'h004;
   localparam logic [OFFSET_W-1:0] OFS_BASE      = 12'h00C;
   localparam logic [OFFSET_W-1:0] OFS_END       = 12'h010;
   localparam logic [OFFSET_W-1:0] OFS_WPTR      = 12'h014;
   localparam logic [OFFSET_W-1:0] OFS_FIFO_RST  = 12'h018;
   localparam logic [OFFSET_W-1:0] OFS_RST_CODE  = 12'h024;
   localparam logic [OFFSET_W-1:0] OFS_BOARD_REV = 12'h02C;

   localparam logic [DATA_W-1:0] RST_CODE_VALUE  = 32'h8000_0000;
   localparam logic [DATA_W-1:0] BOARD_REV_VALUE = 32'h2000_0000;
   localparam logic [DATA_W-1:0] UNKNOWN_VALUE   = 32'hAFFE_0000;
   localparam logic [DATA_W-1:0] RST_CODE_OK_A   = 32'h8000_0001;
   localparam logic [DATA_W-1:0] RST_CODE_OK_B   = 32'h8000_0005;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              irq_pending;
      logic              unknown_access;
      logic              reset_request;
   } rsp_type;

endpackage : icmr_pkg
`default_nettype wire

// ===== rtl/icmr_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icmr_req_if
// Request channel: one bus access or interrupt event per beat.
// ----------------------------------------------------------------------------
interface icmr_req_if;
   import icmr_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   req_type;
   logic [OFFSET_W-1:0] reg_offset;
   logic [DATA_W-1:0]   write_data;
   logic [DATA_W-1:0]   cause_bits;
   logic                line_set;

   modport source (
      output valid, req_type, reg_offset, write_data, cause_bits, line_set,
      input  ready
   );

   modport sink (
      input  valid, req_type, reg_offset, write_data, cause_bits, line_set,
      output ready
   );

endinterface : icmr_req_if
`default_nettype wire

// ===== rtl/icmr_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// icmr_rsp_if
// Response channel: one result beat per request beat.
// ----------------------------------------------------------------------------
interface icmr_rsp_if;
   import icmr_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic              irq_pending;
   logic              unknown_access;
   logic              reset_request;

   modport source (
      output valid, read_data, irq_pending, unknown_access, reset_request,
      input  ready
   );

   modport sink (
      input  valid, read_data, irq_pending, unknown_access, reset_request,
      output ready
   );

endinterface : icmr_rsp_if
`default_nettype wire

// ===== rtl/interrupt_cause_mask_registers_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// interrupt_cause_mask_registers_unit
// Interrupt cause/mask regs with FIFO pointers, one beat per unstalled cycle.
// ----------------------------------------------------------------------------
// Each request beat is a bus read, a bus write, a device interrupt line
// set/clear or a reset button change. The beat is decoded against the
// register state in the cycle it is accepted; the state and the response
// (read data, irq_pending, unknown_access, reset_request) are registered at
// the same edge, so the response appears in the cycle after acceptance. A new
// beat is taken every cycle as long as the response register is empty or
// being drained in that cycle: throughput is one beat per clock. irq_pending
// always reflects cause & mask after the beat, including reset button
// changes. Writes to the cause register clear the bits written as 1; pointer
// registers keep address bits 31..5. After reset the cause register holds
// only the reset button bit; mask, pointers and response valid are zero.
// ----------------------------------------------------------------------------
module interrupt_cause_mask_registers_unit (
   input  wire         clock,
   input  wire         reset,
   icmr_req_if.sink    req_chan,
   icmr_rsp_if.source  rsp_chan
);
   import icmr_pkg::*;

   // Architectural state
   logic [DATA_W-1:0] cause_ff, cause_in;
   logic [DATA_W-1:0] mask_ff,  mask_in;
   logic [PTR_W-1:0]  base_ff,  base_in;
   logic [PTR_W-1:0]  end_ff,   end_in;
   logic [PTR_W-1:0]  wptr_ff,  wptr_in;

   // Response register
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic     req_accept;
   kind_type kind;

   // Response slot frees up when it is empty or taken this cycle.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign kind           = kind_type'(req_chan.req_type);

   // Decode and next state
   always_comb begin
      cause_in              = cause_ff;
      mask_in               = mask_ff;
      base_in               = base_ff;
      end_in                = end_ff;
      wptr_in               = wptr_ff;
      rsp_in.read_data      = '0;
      rsp_in.unknown_access = 1'b0;
      rsp_in.reset_request  = 1'b0;

      unique case (kind)
         KIND_READ: begin
            unique case (req_chan.reg_offset)
               OFS_CAUSE:     rsp_in.read_data = cause_ff;
               OFS_MASK:      rsp_in.read_data = mask_ff;
               OFS_BASE:      rsp_in.read_data = {base_ff, PTR_LSB'(0)};
               OFS_END:       rsp_in.read_data = {end_ff, PTR_LSB'(0)};
               OFS_WPTR:      rsp_in.read_data = {wptr_ff, PTR_LSB'(0)};
               OFS_RST_CODE:  rsp_in.read_data = RST_CODE_VALUE;
               OFS_BOARD_REV: rsp_in.read_data = BOARD_REV_VALUE;
               default: begin
                  // FIFO reset offset reads as unknown too
                  rsp_in.read_data      = UNKNOWN_VALUE;
                  rsp_in.unknown_access = 1'b1;
               end
            endcase
         end
         KIND_WRITE: begin
            unique case (req_chan.reg_offset)
               OFS_CAUSE:    cause_in = cause_ff & ~req_chan.write_data;
               OFS_MASK:     mask_in  = req_chan.write_data;
               OFS_BASE:     base_in  = req_chan.write_data[DATA_W-1:PTR_LSB];
               OFS_END:      end_in   = req_chan.write_data[DATA_W-1:PTR_LSB];
               OFS_WPTR:     wptr_in  = req_chan.write_data[DATA_W-1:PTR_LSB];
               OFS_FIFO_RST: ;
               OFS_RST_CODE: begin
                  rsp_in.reset_request = (req_chan.write_data != RST_CODE_OK_A) &&
                                         (req_chan.write_data != RST_CODE_OK_B);
               end
               default:      rsp_in.unknown_access = 1'b1; // incl. board rev
            endcase
         end
         KIND_LINE: begin
            if (req_chan.line_set) begin
               cause_in = cause_ff | req_chan.cause_bits;
            end else begin
               cause_in = cause_ff & ~req_chan.cause_bits;
            end
         end
         KIND_BUTTON: begin
            // active low: pressed clears the cause bit
            if (req_chan.line_set) begin
               cause_in = cause_ff & ~BUTTON_MASK;
            end else begin
               cause_in = cause_ff | BUTTON_MASK;
            end
         end
         default: ;
      endcase

      rsp_in.irq_pending = |(cause_in & mask_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cause_ff     <= CAUSE_RESET;
         mask_ff      <= '0;
         base_ff      <= '0;
         end_ff       <= '0;
         wptr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            cause_ff     <= cause_in;
            mask_ff      <= mask_in;
            base_ff      <= base_in;
            end_ff       <= end_in;
            wptr_ff      <= wptr_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.read_data      = rsp_ff.read_data;
   assign rsp_chan.irq_pending    = rsp_ff.irq_pending;
   assign rsp_chan.unknown_access = rsp_ff.unknown_access;
   assign rsp_chan.reset_request  = rsp_ff.reset_request;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // Pending irq in the held response matches the live state.
   a_irq_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.irq_pending == |(cause_ff & mask_ff)))
      else $error("irq_pending disagrees with cause & mask");

   // A beat cannot be both an unknown access and a reset request.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.unknown_access && rsp_ff.reset_request))
      else $error("unknown_access and reset_request both set");

   // State only moves on an accepted beat.
   a_state_holds: assert property (@(posedge clock)
      (!reset && !req_accept) |=> ($stable(cause_ff) && $stable(mask_ff)))
      else $error("state changed without an accepted beat");

   // Reset leaves only the button cause bit set.
   a_reset_value: assert property (@(posedge clock)
      reset |=> (cause_ff == CAUSE_RESET) && (mask_ff == '0) && !rsp_valid_ff)
      else $error("bad register state after reset");

endmodule : interrupt_cause_mask_registers_unit
`default_nettype wire

// ===== dv/interrupt_cause_mask_registers_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interrupt_cause_mask_registers_unit_tb
// Self-checking bench for the interrupt cause/mask register block: a directed
// pass over every register, flag and button case, then random bus accesses,
// interrupt line events and button changes with bursty idling on both
// channels. Each response beat is checked against a cycle-free register
// predictor.
// ----------------------------------------------------------------------------

module interrupt_cause_mask_registers_unit_tb;
   import icmr_pkg::*;

   // Register predictor plus ordered store of expected response beats.
   class irq_reg_scoreboard;
      logic [DATA_W-1:0] cause_q;
      logic [DATA_W-1:0] mask_q;
      logic [PTR_W-1:0]  base_ptr_q;
      logic [PTR_W-1:0]  end_ptr_q;
      logic [PTR_W-1:0]  wr_ptr_q;

      rsp_type expected_rsps[$];
      int      mismatch_count;

      function new();
         cause_q        = CAUSE_RESET;
         mask_q         = '0;
         base_ptr_q     = '0;
         end_ptr_q      = '0;
         wr_ptr_q       = '0;
         mismatch_count = 0;
      endfunction

      // Apply one accepted request beat and queue the response it must produce.
      function void note_request(kind_type kind, logic [OFFSET_W-1:0] ofs,
                                 logic [DATA_W-1:0] wdata, logic [DATA_W-1:0] cbits,
                                 logic set);
         rsp_type exp_rsp;
         exp_rsp = '0;
         case (kind)
            KIND_READ: begin
               case (ofs)
                  OFS_CAUSE:     exp_rsp.read_data = cause_q;
                  OFS_MASK:      exp_rsp.read_data = mask_q;
                  OFS_BASE:      exp_rsp.read_data = {base_ptr_q, 5'b0};
                  OFS_END:       exp_rsp.read_data = {end_ptr_q, 5'b0};
                  OFS_WPTR:      exp_rsp.read_data = {wr_ptr_q, 5'b0};
                  OFS_RST_CODE:  exp_rsp.read_data = RST_CODE_VALUE;
                  OFS_BOARD_REV: exp_rsp.read_data = BOARD_REV_VALUE;
                  default: begin
                     exp_rsp.read_data      = UNKNOWN_VALUE;
                     exp_rsp.unknown_access = 1'b1;
                  end
               endcase
            end
            KIND_WRITE: begin
               case (ofs)
                  OFS_CAUSE:    cause_q    = cause_q & ~wdata;
                  OFS_MASK:     mask_q     = wdata;
                  OFS_BASE:     base_ptr_q = wdata[DATA_W-1:PTR_LSB];
                  OFS_END:      end_ptr_q  = wdata[DATA_W-1:PTR_LSB];
                  OFS_WPTR:     wr_ptr_q   = wdata[DATA_W-1:PTR_LSB];
                  OFS_FIFO_RST: ;
                  OFS_RST_CODE:
                     exp_rsp.reset_request = (wdata != RST_CODE_OK_A) &&
                                             (wdata != RST_CODE_OK_B);
                  default:      exp_rsp.unknown_access = 1'b1;
               endcase
            end
            KIND_LINE: begin
               if (set) cause_q = cause_q | cbits;
               else     cause_q = cause_q & ~cbits;
            end
            default: begin
               // button is active low: pressed clears its cause bit
               if (set) cause_q = cause_q & ~BUTTON_MASK;
               else     cause_q = cause_q | BUTTON_MASK;
            end
         endcase
         exp_rsp.irq_pending = |(cause_q & mask_q);
         expected_rsps.push_back(exp_rsp);
      endfunction

      // Compare one accepted response beat with the oldest expectation.
      function void check_response(rsp_type got);
         rsp_type exp_rsp;
         if (expected_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected beat: data %h irq %b unk %b rst %b",
                        $realtime, got.read_data, got.irq_pending,
                        got.unknown_access, got.reset_request);
            return;
         end
         exp_rsp = expected_rsps.pop_front();
         if (got !== exp_rsp) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: exp data %h irq %b unk %b rst %b, got %h %b %b %b",
                        $realtime, exp_rsp.read_data, exp_rsp.irq_pending,
                        exp_rsp.unknown_access, exp_rsp.reset_request,
                        got.read_data, got.irq_pending, got.unknown_access,
                        got.reset_request);
         end
      endfunction
   endclass

   localparam int RANDOM_BEATS = 1950;
   localparam int QUIET_BEATS  = 250;   // tail of the run with no idling

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   quiet_phase = 1'b0;

   irq_reg_scoreboard sb = new();

   icmr_req_if req_bus ();
   icmr_rsp_if rsp_bus ();

   interrupt_cause_mask_registers_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #5 clock = ~clock;

   // Hard stop in case the block hangs a handshake.
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Both channels are sampled at the rising edge; the predictor advances on
   // every accepted request beat, the checker on every accepted response beat.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready)
            sb.check_response(rsp_type'{read_data:      rsp_bus.read_data,
                                        irq_pending:    rsp_bus.irq_pending,
                                        unknown_access: rsp_bus.unknown_access,
                                        reset_request:  rsp_bus.reset_request});
         if (req_bus.valid && req_bus.ready)
            sb.note_request(kind_type'(req_bus.req_type), req_bus.reg_offset,
                            req_bus.write_data, req_bus.cause_bits, req_bus.line_set);
      end
   end

   // Response back-pressure: ready drops at random, never in the quiet tail.
   // Changes only at the falling edge.
   initial begin
      rsp_bus.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // Present one request beat and hold it until accepted. Entered and left at
   // a falling edge; an optional idle burst goes first.
   task automatic send_beat(input kind_type kind, input logic [OFFSET_W-1:0] ofs,
                            input logic [DATA_W-1:0] wdata,
                            input logic [DATA_W-1:0] cbits, input logic set);
      begin
         if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            req_bus.valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         req_bus.valid      = 1'b1;
         req_bus.req_type   = kind;
         req_bus.reg_offset = ofs;
         req_bus.write_data = wdata;
         req_bus.cause_bits = cbits;
         req_bus.line_set   = set;
         do @(posedge clock); while (!req_bus.ready);
         @(negedge clock);
      end
   endtask

   initial begin : stimulus
      int                  n;
      kind_type            kind;
      logic [OFFSET_W-1:0] ofs;
      logic [DATA_W-1:0]   wdata;
      logic [DATA_W-1:0]   cbits;

      req_bus.valid      = 1'b0;
      req_bus.req_type   = KIND_READ;
      req_bus.reg_offset = '0;
      req_bus.write_data = '0;
      req_bus.cause_bits = '0;
      req_bus.line_set   = 1'b0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // --- directed pass ---
      // reset values: cause holds only the button bit, mask clear
      send_beat(KIND_READ,   OFS_CAUSE, '0, '0, 1'b0);
      send_beat(KIND_READ,   OFS_MASK,  '0, '0, 1'b0);
      send_beat(KIND_WRITE,  OFS_MASK,  '1, '0, 1'b0);
      // button press clears its cause bit, release sets it again
      send_beat(KIND_BUTTON, '1, '1, '1, 1'b1);
      send_beat(KIND_BUTTON, '0, '0, '0, 1'b0);
      // line set/clear, then write-one-to-clear on the cause register
      send_beat(KIND_LINE,   '0, '0, '1, 1'b1);
      send_beat(KIND_READ,   OFS_CAUSE, '0, '0, 1'b0);
      send_beat(KIND_LINE,   '0, '0, 32'hFFFF_0000, 1'b0);
      send_beat(KIND_WRITE,  OFS_CAUSE, '1, '0, 1'b0);
      send_beat(KIND_READ,   OFS_CAUSE, '0, '0, 1'b0);
      // pointers keep only address bits 31..5
      send_beat(KIND_WRITE,  OFS_BASE, '1, '0, 1'b0);
      send_beat(KIND_READ,   OFS_BASE, '0, '0, 1'b0);
      send_beat(KIND_WRITE,  OFS_END, 32'h0000_001F, '0, 1'b0);
      send_beat(KIND_READ,   OFS_END, '0, '0, 1'b0);
      send_beat(KIND_WRITE,  OFS_WPTR, 32'hA5A5_A5A5, '0, 1'b0);
      send_beat(KIND_READ,   OFS_WPTR, '0, '0, 1'b0);
      // FIFO reset: write ignored, read unknown
      send_beat(KIND_WRITE,  OFS_FIFO_RST, '1, '0, 1'b0);
      send_beat(KIND_READ,   OFS_FIFO_RST, '0, '0, 1'b0);
      // reset code: two allowed values, anything else requests a reset
      send_beat(KIND_WRITE,  OFS_RST_CODE, RST_CODE_OK_A, '0, 1'b0);
      send_beat(KIND_WRITE,  OFS_RST_CODE, RST_CODE_OK_B, '0, 1'b0);
      send_beat(KIND_WRITE,  OFS_RST_CODE, '0, '0, 1'b0);
      send_beat(KIND_READ,   OFS_RST_CODE, '0, '0, 1'b0);
      // board revision reads fine, writes are unknown
      send_beat(KIND_READ,   OFS_BOARD_REV, '0, '0, 1'b0);
      send_beat(KIND_WRITE,  OFS_BOARD_REV, '1, '0, 1'b0);
      // unknown offsets at the top of the range
      send_beat(KIND_READ,   '1, '0, '0, 1'b0);
      send_beat(KIND_WRITE,  '1, '1, '0, 1'b0);
      send_beat(KIND_WRITE,  OFS_MASK, '0, '0, 1'b0);

      // --- random pass ---
      for (n = 0; n < RANDOM_BEATS; n++) begin
         if (n == RANDOM_BEATS - QUIET_BEATS)
            quiet_phase = 1'b1;

         case ($urandom_range(0, 9))
            0, 1, 2:       kind = KIND_READ;
            3, 4, 5, 6:    kind = KIND_WRITE;
            7, 8:          kind = KIND_LINE;
            default:       kind = KIND_BUTTON;
         endcase

         // mostly mapped registers, some random (mostly unknown) offsets
         case ($urandom_range(0, 9))
            0:       ofs = OFS_CAUSE;
            1:       ofs = OFS_MASK;
            2:       ofs = OFS_BASE;
            3:       ofs = OFS_END;
            4:       ofs = OFS_WPTR;
            5:       ofs = OFS_FIFO_RST;
            6:       ofs = OFS_RST_CODE;
            7:       ofs = OFS_BOARD_REV;
            default: ofs = OFFSET_W'($urandom_range(0, 4095));
         endcase

         // sparse values keep cause & mask toggling between hit and miss
         case ($urandom_range(0, 5))
            0:       wdata = '0;
            1:       wdata = DATA_W'(1) << $urandom_range(0, 31);
            default: wdata = $urandom;
         endcase
         if (kind == KIND_WRITE && ofs == OFS_RST_CODE && $urandom_range(0, 1))
            wdata = $urandom_range(0, 1) ? RST_CODE_OK_A : RST_CODE_OK_B;

         case ($urandom_range(0, 3))
            0:       cbits = DATA_W'(1) << $urandom_range(0, 31);
            1:       cbits = BUTTON_MASK;
            default: cbits = $urandom;
         endcase

         send_beat(kind, ofs, wdata, cbits, 1'($urandom_range(0, 1)));
      end
      req_bus.valid = 1'b0;

      // drain, then wait for any stray beat
      while (sb.expected_rsps.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (sb.mismatch_count == 0 && sb.expected_rsps.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== interrupt_cause_mask_registers_unit.f =====
rtl/icmr_pkg.sv
rtl/icmr_req_if.sv
rtl/icmr_rsp_if.sv
rtl/interrupt_cause_mask_registers_unit.sv
dv/interrupt_cause_mask_registers_unit_tb.sv
